// File: hdl/hpsw_pkg.sv
// Shared types, phase codes and helpers for the headset profile switch block.
package hpsw_pkg;

    localparam int unsigned GEN_W   = 64;
    localparam int unsigned TIME_W  = 64;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned PHASE_W = 3;

    localparam logic [CFG_W-1:0] RELEASE_STABILITY_RESET = CFG_W'(500);

    // Encoded phase values as they appear on the result port.
    localparam logic [PHASE_W-1:0] PH_CODE_DISCONNECTED = 3'd0;
    localparam logic [PHASE_W-1:0] PH_CODE_CODEC_AVAIL  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_CODE_WAIT_STOP    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_CODE_VOICE        = 3'd3;
    localparam logic [PHASE_W-1:0] PH_CODE_RELEASE      = 3'd4;

    typedef enum logic [4:0] {
        PH_DISCONNECTED = 5'b00001,
        PH_CODEC_AVAIL  = 5'b00010,
        PH_WAIT_STOP    = 5'b00100,
        PH_VOICE        = 5'b01000,
        PH_RELEASE      = 5'b10000
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        logic [GEN_W-1:0]    generation;
        logic [TIME_W-1:0]   deadline;
        logic                voice_on;
    } t_hpsw_state;

    typedef struct packed {
        logic [GEN_W-1:0]    link_generation;
        logic                plugged_in;
        logic                mic_capture;
        logic                codec_path_active;
        logic                play_wanted;
        logic [TIME_W-1:0]   now_ms;
    } t_hpsw_event;

    typedef struct packed {
        logic                act_stop_codec;
        logic                act_enter_voice;
        logic                act_exit_voice;
        logic                act_resume_codec;
        logic                stale;
    } t_hpsw_flags;

    function automatic logic [PHASE_W-1:0] phase_code(input t_phase ph);
        logic [PHASE_W-1:0] code;
        case (ph)
            PH_DISCONNECTED: code = PH_CODE_DISCONNECTED;
            PH_CODEC_AVAIL:  code = PH_CODE_CODEC_AVAIL;
            PH_WAIT_STOP:    code = PH_CODE_WAIT_STOP;
            PH_VOICE:        code = PH_CODE_VOICE;
            PH_RELEASE:      code = PH_CODE_RELEASE;
            default:         code = PH_CODE_DISCONNECTED;
        endcase
        return code;
    endfunction

endpackage

// File: hdl/hpsw_next.sv
// Next-state and action logic for one status event of the profile switch.
module hpsw_next
    import hpsw_pkg::*;
(
    input  t_hpsw_state        i_state,
    input  t_hpsw_event        i_evt,
    input  logic [CFG_W-1:0]   i_stability_ms,
    output t_hpsw_state        o_state,
    output t_hpsw_flags        o_flags
);

    logic [GEN_W-1:0]  gen_diff;
    logic              gen_newer;
    logic              gen_stale;
    logic              gen_change;
    logic [TIME_W-1:0] deadline_sum;

    // Serial-number compare: newer when the wrapped difference is in the lower half range.
    assign gen_diff     = i_evt.link_generation - i_state.generation;
    assign gen_newer    = (gen_diff != '0) && !gen_diff[GEN_W-1];
    assign gen_change   = (i_evt.link_generation != i_state.generation);
    assign gen_stale    = (i_evt.link_generation == '0) ||
                          ((i_state.generation != '0) && gen_change && !gen_newer);
    assign deadline_sum = i_evt.now_ms + TIME_W'(i_stability_ms);

    always_comb begin
        t_hpsw_state s;
        t_hpsw_flags f;
        s = i_state;
        f = '0;

        if (gen_stale) begin
            f.stale = 1'b1;
        end else begin
            // New generation: restart the machine.
            if (gen_change) begin
                f.act_exit_voice = s.voice_on;
                s.generation     = i_evt.link_generation;
                s.phase          = PH_DISCONNECTED;
                s.deadline       = '0;
                s.voice_on       = 1'b0;
            end

            if (!i_evt.plugged_in) begin
                f.act_exit_voice = f.act_exit_voice | s.voice_on;
                s.phase          = PH_DISCONNECTED;
                s.deadline       = '0;
                s.voice_on       = 1'b0;
            end else begin
                if (s.phase == PH_DISCONNECTED) begin
                    s.phase = PH_CODEC_AVAIL;
                end

                if (i_evt.mic_capture) begin
                    s.deadline = '0;
                    if (i_evt.codec_path_active) begin
                        f.act_stop_codec = (s.phase != PH_WAIT_STOP);
                        s.phase          = PH_WAIT_STOP;
                    end else begin
                        f.act_enter_voice = !s.voice_on;
                        s.voice_on        = 1'b1;
                        s.phase           = PH_VOICE;
                    end
                end else begin
                    case (s.phase)
                        PH_WAIT_STOP: begin
                            if (!i_evt.codec_path_active) begin
                                s.phase    = PH_RELEASE;
                                s.deadline = deadline_sum;
                            end
                        end
                        PH_VOICE: begin
                            s.phase    = PH_RELEASE;
                            s.deadline = deadline_sum;
                        end
                        PH_RELEASE: begin
                            if (i_evt.now_ms >= s.deadline) begin
                                f.act_exit_voice   = s.voice_on;
                                s.voice_on         = 1'b0;
                                f.act_resume_codec = i_evt.play_wanted &&
                                                     !i_evt.codec_path_active;
                                s.phase            = PH_CODEC_AVAIL;
                                s.deadline         = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end

        o_state = s;
        o_flags = f;
    end

endmodule

// File: hdl/headset_profile_switch_fsm_unit.sv
// Top level of the headset profile switch state machine.
//
// Each accepted request is one headset status event; the block answers it with exactly
// one result carrying the four action bits, the phase after the event, the accepted link
// generation, the release deadline and the stale flag. The full decision (generation
// compare, deadline add, phase update) is combinational logic between the input handshake
// and the result register, so an event is taken every cycle unless the receiver stalls: the
// result follows in the next cycle, and the next request is taken in the same cycle that the
// previous result leaves. The result register is the only buffering; while it holds an
// untaken result, o_ready stays low. The release stability time is written through
// i_cfg_we / i_cfg_wdata and resets to 500 ms; write it only while no result is pending.
module headset_profile_switch_fsm_unit
    import hpsw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_we,
    input  logic [CFG_W-1:0]     i_cfg_wdata,

    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [GEN_W-1:0]     i_link_generation,
    input  logic                 i_physical_connected,
    input  logic                 i_capture_active,
    input  logic                 i_codec_path_active,
    input  logic                 i_render_demand,
    input  logic [TIME_W-1:0]    i_now_ms,

    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_act_stop_codec,
    output logic                 o_act_enter_voice,
    output logic                 o_act_exit_voice,
    output logic                 o_act_resume_codec,
    output logic [PHASE_W-1:0]   o_phase_out,
    output logic [GEN_W-1:0]     o_generation_out,
    output logic [TIME_W-1:0]    o_deadline_out,
    output logic                 o_stale
);

    logic [CFG_W-1:0] r_stability_ms;
    t_hpsw_state      r_state;
    t_hpsw_state      n_state;
    t_hpsw_flags      n_flags;
    t_hpsw_flags      r_flags;
    logic             r_out_valid;
    logic             accept;
    t_hpsw_event      evt;

    // Take a request when the result slot is empty or being drained this cycle.
    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    assign evt = '{
        link_generation:    i_link_generation,
        plugged_in:         i_physical_connected,
        mic_capture:        i_capture_active,
        codec_path_active:  i_codec_path_active,
        play_wanted:        i_render_demand,
        now_ms:             i_now_ms
    };

    hpsw_next u_next (
        .i_state        (r_state),
        .i_evt          (evt),
        .i_stability_ms (r_stability_ms),
        .o_state        (n_state),
        .o_flags        (n_flags)
    );

    // Configuration register: written directly, no handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stability_ms <= RELEASE_STABILITY_RESET;
        end else if (i_cfg_we) begin
            r_stability_ms <= i_cfg_wdata;
        end
    end

    // Machine state: advance on every accepted request (stale events leave it unchanged).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase      <= PH_DISCONNECTED;
            r_state.generation <= '0;
            r_state.deadline   <= '0;
            r_state.voice_on   <= 1'b0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // Result valid: set on accept, drop when taken without a replacement.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result flags: payload only, hold until the next accept.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_flags <= n_flags;
        end
    end

    // Phase, generation and deadline on the result port mirror the state after the event.
    assign o_valid            = r_out_valid;
    assign o_act_stop_codec   = r_flags.act_stop_codec;
    assign o_act_enter_voice  = r_flags.act_enter_voice;
    assign o_act_exit_voice   = r_flags.act_exit_voice;
    assign o_act_resume_codec = r_flags.act_resume_codec;
    assign o_stale            = r_flags.stale;
    assign o_phase_out        = phase_code(r_state.phase);
    assign o_generation_out   = r_state.generation;
    assign o_deadline_out     = r_state.deadline;

endmodule

// File: hdl/hpsw_checker.sv
// Port-level checks for the headset profile switch, bound to the top level.
module hpsw_checker
    import hpsw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 o_valid,
    input  logic                 i_ready,
    input  logic                 o_act_stop_codec,
    input  logic                 o_act_enter_voice,
    input  logic                 o_act_exit_voice,
    input  logic                 o_act_resume_codec,
    input  logic [PHASE_W-1:0]   o_phase_out,
    input  logic [GEN_W-1:0]     o_generation_out,
    input  logic [TIME_W-1:0]    o_deadline_out,
    input  logic                 o_stale
);

    // A rejected event requests nothing.
    a_stale_no_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stale) |->
            !(o_act_stop_codec || o_act_enter_voice || o_act_exit_voice || o_act_resume_codec))
        else $error("stale result carries an action");

    // An accepted event always leaves a nonzero generation.
    a_fresh_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_stale) |-> (o_generation_out != '0))
        else $error("fresh result with generation zero");

    // A codec stop request leaves the machine waiting for the stop.
    a_stop_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_act_stop_codec) |-> (o_phase_out == PH_CODE_WAIT_STOP))
        else $error("codec stop outside the wait phase");

    // Outside the release phase no deadline is pending.
    a_deadline_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_phase_out != PH_CODE_RELEASE) |-> (o_deadline_out == '0))
        else $error("deadline set outside the release phase");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_phase_out) && $stable(o_stale)))
        else $error("stalled result changed");

endmodule

bind headset_profile_switch_fsm_unit hpsw_checker u_hpsw_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_valid            (o_valid),
    .i_ready            (i_ready),
    .o_act_stop_codec   (o_act_stop_codec),
    .o_act_enter_voice  (o_act_enter_voice),
    .o_act_exit_voice   (o_act_exit_voice),
    .o_act_resume_codec (o_act_resume_codec),
    .o_phase_out        (o_phase_out),
    .o_generation_out   (o_generation_out),
    .o_deadline_out     (o_deadline_out),
    .o_stale            (o_stale)
);

// File: tb/sv/hpsw_switch_checker.sv
// Checker for the headset profile switch: tracks the machine, predicts each result, compares.
`timescale 1ns / 1ps

module hpsw_switch_checker
    import hpsw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_we,
    input  logic [CFG_W-1:0]     i_cfg_wdata,

    input  logic                 i_req_valid,
    input  logic                 i_req_ready,
    input  logic [GEN_W-1:0]     i_link_generation,
    input  logic                 i_physical_connected,
    input  logic                 i_capture_active,
    input  logic                 i_codec_path_active,
    input  logic                 i_render_demand,
    input  logic [TIME_W-1:0]    i_now_ms,

    input  logic                 i_res_valid,
    input  logic                 i_res_ready,
    input  logic                 i_act_stop_codec,
    input  logic                 i_act_enter_voice,
    input  logic                 i_act_exit_voice,
    input  logic                 i_act_resume_codec,
    input  logic [PHASE_W-1:0]   i_phase_out,
    input  logic [GEN_W-1:0]     i_generation_out,
    input  logic [TIME_W-1:0]    i_deadline_out,
    input  logic                 i_stale,

    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic                stop_codec;
        logic                enter_voice;
        logic                exit_voice;
        logic                resume_codec;
        logic [PHASE_W-1:0]  phase;
        logic [GEN_W-1:0]    generation;
        logic [TIME_W-1:0]   deadline;
        logic                stale;
    } t_switch_result;

    // Predicted machine state and the release delay register.
    logic [PHASE_W-1:0]  sw_phase;
    logic [GEN_W-1:0]    sw_generation;
    logic [TIME_W-1:0]   sw_deadline;
    logic                sw_voice_on;
    logic [CFG_W-1:0]    release_ms;

    t_switch_result      predicted_switch_results[$];
    int                  fails;

    // Serial-number compare: newer when the forward distance is below half range.
    function automatic bit generation_is_newer(input logic [GEN_W-1:0] cand,
                                               input logic [GEN_W-1:0] cur);
        logic [GEN_W-1:0] fwd_gap;
        fwd_gap = cand - cur;
        if (cand == '0) return 1'b0;
        if (cur == '0) return 1'b1;
        return (fwd_gap != '0) && !fwd_gap[GEN_W-1];
    endfunction

    function automatic void drop_to_disconnected();
        sw_phase    = PH_CODE_DISCONNECTED;
        sw_deadline = '0;
        sw_voice_on = 1'b0;
    endfunction

    // Apply one status event to the predicted state and return the result it causes.
    function automatic t_switch_result advance_switch_state(input t_hpsw_event ev);
        t_switch_result r;
        r = '0;
        if (ev.link_generation == '0 ||
            (sw_generation != '0 && ev.link_generation != sw_generation &&
             !generation_is_newer(ev.link_generation, sw_generation))) begin
            r.stale = 1'b1;
        end else begin
            if (ev.link_generation != sw_generation) begin
                if (sw_voice_on) r.exit_voice = 1'b1;
                sw_generation = ev.link_generation;
                drop_to_disconnected();
                if (ev.plugged_in) sw_phase = PH_CODE_CODEC_AVAIL;
            end
            if (!ev.plugged_in) begin
                if (sw_voice_on) r.exit_voice = 1'b1;
                drop_to_disconnected();
            end else begin
                if (sw_phase == PH_CODE_DISCONNECTED) sw_phase = PH_CODE_CODEC_AVAIL;
                if (ev.mic_capture) begin
                    sw_deadline = '0;
                    if (ev.codec_path_active) begin
                        if (sw_phase != PH_CODE_WAIT_STOP) r.stop_codec = 1'b1;
                        sw_phase = PH_CODE_WAIT_STOP;
                    end else begin
                        if (!sw_voice_on) begin
                            r.enter_voice = 1'b1;
                            sw_voice_on   = 1'b1;
                        end
                        sw_phase = PH_CODE_VOICE;
                    end
                end else if (sw_phase == PH_CODE_WAIT_STOP) begin
                    if (!ev.codec_path_active) begin
                        sw_phase    = PH_CODE_RELEASE;
                        sw_deadline = ev.now_ms + TIME_W'(release_ms);
                    end
                end else if (sw_phase == PH_CODE_VOICE) begin
                    sw_phase    = PH_CODE_RELEASE;
                    sw_deadline = ev.now_ms + TIME_W'(release_ms);
                end else if (sw_phase == PH_CODE_RELEASE && ev.now_ms >= sw_deadline) begin
                    if (sw_voice_on) begin
                        r.exit_voice = 1'b1;
                        sw_voice_on  = 1'b0;
                    end
                    if (ev.play_wanted && !ev.codec_path_active) r.resume_codec = 1'b1;
                    sw_phase    = PH_CODE_CODEC_AVAIL;
                    sw_deadline = '0;
                end
            end
        end
        r.phase      = sw_phase;
        r.generation = sw_generation;
        r.deadline   = sw_deadline;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_switch_result got;
        t_switch_result want;
        t_hpsw_event    ev;
        logic           bad;
        if (!i_rst_n) begin
            sw_generation = '0;
            drop_to_disconnected();
            release_ms = RELEASE_STABILITY_RESET;
            predicted_switch_results.delete();
            fails = 0;
        end else begin
            if (i_cfg_we) release_ms = i_cfg_wdata;

            // Retire the result first so a request taken on the same edge cannot match it.
            if (i_res_valid && i_res_ready) begin
                got.stop_codec   = i_act_stop_codec;
                got.enter_voice  = i_act_enter_voice;
                got.exit_voice   = i_act_exit_voice;
                got.resume_codec = i_act_resume_codec;
                got.phase        = i_phase_out;
                got.generation   = i_generation_out;
                got.deadline     = i_deadline_out;
                got.stale        = i_stale;
                if (predicted_switch_results.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("[%0t] unexpected result: phase=%0d gen=%h", $realtime,
                                 got.phase, got.generation);
                end else begin
                    want = predicted_switch_results.pop_front();
                    bad = (got.stop_codec   !== want.stop_codec)   ||
                          (got.enter_voice  !== want.enter_voice)  ||
                          (got.exit_voice   !== want.exit_voice)   ||
                          (got.resume_codec !== want.resume_codec) ||
                          (got.phase        !== want.phase)        ||
                          (got.generation   !== want.generation)   ||
                          (got.deadline     !== want.deadline)     ||
                          (got.stale        !== want.stale);
                    if (bad) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("[%0t] result mismatch", $realtime);
                            $display("  exp: stop=%b enter=%b exit=%b resume=%b",
                                     want.stop_codec, want.enter_voice, want.exit_voice,
                                     want.resume_codec);
                            $display("       ph=%0d gen=%h dl=%h st=%b",
                                     want.phase, want.generation, want.deadline,
                                     want.stale);
                            $display("  got: stop=%b enter=%b exit=%b resume=%b",
                                     got.stop_codec, got.enter_voice, got.exit_voice,
                                     got.resume_codec);
                            $display("       ph=%0d gen=%h dl=%h st=%b",
                                     got.phase, got.generation, got.deadline,
                                     got.stale);
                        end
                    end
                end
            end

            if (i_req_valid && i_req_ready) begin
                ev.link_generation    = i_link_generation;
                ev.plugged_in         = i_physical_connected;
                ev.mic_capture        = i_capture_active;
                ev.codec_path_active  = i_codec_path_active;
                ev.play_wanted        = i_render_demand;
                ev.now_ms             = i_now_ms;
                predicted_switch_results.push_back(advance_switch_state(ev));
            end
        end
        o_fail_count <= fails;
        o_pending    <= predicted_switch_results.size();
    end

endmodule

// File: tb/sv/tb_headset_profile_switch_fsm_unit.sv
// Testbench top for the headset profile switch: clock, reset, requests, receiver stalls, verdict.
`timescale 1ns / 1ps

module tb_headset_profile_switch_fsm_unit;
    import hpsw_pkg::*;

    localparam int IDLE_LIMIT   = 4000;   // cycles with no handshake before giving up
    localparam int PHASE_ITEMS  = 238;    // random requests per configuration phase
    localparam logic [GEN_W-1:0] GEN_HALF_SPAN = 64'h8000_0000_0000_0000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CFG_W-1:0]    i_cfg_wdata;
    logic                i_valid;
    logic                o_ready;
    logic [GEN_W-1:0]    i_link_generation;
    logic                i_physical_connected;
    logic                i_capture_active;
    logic                i_codec_path_active;
    logic                i_render_demand;
    logic [TIME_W-1:0]   i_now_ms;
    logic                o_valid;
    logic                i_ready;
    logic                o_act_stop_codec;
    logic                o_act_enter_voice;
    logic                o_act_exit_voice;
    logic                o_act_resume_codec;
    logic [PHASE_W-1:0]  o_phase_out;
    logic [GEN_W-1:0]    o_generation_out;
    logic [TIME_W-1:0]   o_deadline_out;
    logic                o_stale;

    int                  fail_count;
    int                  pending_results;

    // Stimulus bookkeeping: the generation the block should hold, the running clock
    // of the headset and the release delay currently programmed.
    logic [GEN_W-1:0]    gen_cur;
    logic [TIME_W-1:0]   now_cur;
    logic [CFG_W-1:0]    stab_cur;
    int                  sent;
    int                  burst_left;
    bit                  gap_free;
    bit                  random_active;

    headset_profile_switch_fsm_unit u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_link_generation    (i_link_generation),
        .i_physical_connected (i_physical_connected),
        .i_capture_active     (i_capture_active),
        .i_codec_path_active  (i_codec_path_active),
        .i_render_demand      (i_render_demand),
        .i_now_ms             (i_now_ms),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_act_stop_codec     (o_act_stop_codec),
        .o_act_enter_voice    (o_act_enter_voice),
        .o_act_exit_voice     (o_act_exit_voice),
        .o_act_resume_codec   (o_act_resume_codec),
        .o_phase_out          (o_phase_out),
        .o_generation_out     (o_generation_out),
        .o_deadline_out       (o_deadline_out),
        .o_stale              (o_stale)
    );

    hpsw_switch_checker u_checker (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_req_valid          (i_valid),
        .i_req_ready          (o_ready),
        .i_link_generation    (i_link_generation),
        .i_physical_connected (i_physical_connected),
        .i_capture_active     (i_capture_active),
        .i_codec_path_active  (i_codec_path_active),
        .i_render_demand      (i_render_demand),
        .i_now_ms             (i_now_ms),
        .i_res_valid          (o_valid),
        .i_res_ready          (i_ready),
        .i_act_stop_codec     (o_act_stop_codec),
        .i_act_enter_voice    (o_act_enter_voice),
        .i_act_exit_voice     (o_act_exit_voice),
        .i_act_resume_codec   (o_act_resume_codec),
        .i_phase_out          (o_phase_out),
        .i_generation_out     (o_generation_out),
        .i_deadline_out       (o_deadline_out),
        .i_stale              (o_stale),
        .o_fail_count         (fail_count),
        .o_pending            (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Offer one status request and hold it until the block takes it. Bursts of random
    // length are separated by random gaps unless the current phase runs gap free.
    task automatic send_status(input logic [GEN_W-1:0] gen, input logic conn,
                               input logic cap, input logic codec, input logic render,
                               input logic [TIME_W-1:0] now);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!gap_free) begin
                gap = $urandom_range(1, 6);
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid              <= 1'b1;
        i_link_generation    <= gen;
        i_physical_connected <= conn;
        i_capture_active     <= cap;
        i_codec_path_active  <= codec;
        i_render_demand      <= render;
        i_now_ms             <= now;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sent++;
    endtask

    // Drop valid and hold until every predicted result has been taken.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_release_delay(input logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        stab_cur     = value;
    endtask

    // Advance the headset clock. Past-deadline steps land at or just beyond the release
    // delay; other steps range from a tick to a large jump.
    function automatic logic [TIME_W-1:0] next_time(input bit past_deadline);
        logic [TIME_W-1:0] delta_ms;
        if (past_deadline) begin
            delta_ms = TIME_W'(stab_cur) + TIME_W'($urandom_range(0, 2));
        end else begin
            case ($urandom_range(0, 4))
                0:       delta_ms = TIME_W'($urandom_range(0, 3));
                1:       delta_ms = TIME_W'(stab_cur >> 1);
                2:       delta_ms = TIME_W'(stab_cur);
                3:       delta_ms = (stab_cur != '0) ? TIME_W'(stab_cur) - 1 : '0;
                default: delta_ms = {$urandom, $urandom} >> $urandom_range(8, 40);
            endcase
        end
        now_cur = now_cur + delta_ms;
        return now_cur;
    endfunction

    // Pick a generation: mostly the current one, else invalid, older, exactly half range
    // away, newer by a little or a lot, or fully random. Track it when it is newer.
    function automatic logic [GEN_W-1:0] pick_generation();
        logic [GEN_W-1:0] g;
        logic [GEN_W-1:0] fwd_gap;
        case ($urandom_range(0, 13))
            0:       g = '0;
            1:       g = gen_cur - GEN_W'($urandom_range(1, 4));
            2:       g = gen_cur + {1'b1, 31'($urandom), 32'($urandom)};
            3:       g = gen_cur + GEN_HALF_SPAN;
            4:       g = gen_cur + {1'b0, 31'($urandom), 32'($urandom)};
            5:       g = gen_cur + GEN_W'($urandom_range(1, 3));
            6:       g = {$urandom, $urandom};
            default: g = gen_cur;
        endcase
        fwd_gap = g - gen_cur;
        if (g != '0 && fwd_gap != '0 && !fwd_gap[GEN_W-1]) gen_cur = g;
        return g;
    endfunction

    // One well-formed switch: codec stop, voice, release, then time out the release.
    // A rare disconnect breaks the sequence midway.
    task automatic play_switch_cycle();
        int n;
        if ($urandom_range(0, 3) == 0) begin
            gen_cur = gen_cur + GEN_W'($urandom_range(1, 3));
            if (gen_cur == '0) gen_cur = 1;
        end
        n = $urandom_range(0, 2);
        repeat (n) send_status(gen_cur, 1'b1, 1'b1, 1'b1, 1'($urandom), next_time(1'b0));
        n = $urandom_range(1, 3);
        repeat (n) send_status(gen_cur, ($urandom_range(0, 19) != 0), 1'b1, 1'b0,
                               1'($urandom), next_time(1'b0));
        n = $urandom_range(0, 2);
        repeat (n) send_status(gen_cur, 1'b1, 1'b0, 1'($urandom), 1'($urandom),
                               now_cur + TIME_W'($urandom_range(0, 3)));
        send_status(gen_cur, 1'b1, 1'b0, 1'($urandom), 1'($urandom), next_time(1'b1));
    endtask

    // Noise: random flags, any generation, and now and then a wild or wrapping time.
    task automatic send_noise();
        logic [TIME_W-1:0] now;
        logic [GEN_W-1:0]  gen;
        gen = pick_generation();
        case ($urandom_range(0, 9))
            0:       now = {$urandom, $urandom};
            1: begin
                now_cur = 64'hFFFF_FFFF_FFFF_FFFF - TIME_W'($urandom_range(0, 600));
                now     = now_cur;
            end
            default: now = next_time(1'b0);
        endcase
        send_status(gen, ($urandom_range(0, 3) != 0), 1'($urandom), 1'($urandom),
                    1'($urandom), now);
    endtask

    // Receiver: stretches of always-ready, coin-flip, one-in-three and mostly-ready
    // stalls. Once random traffic is running, hold ready low for a long stretch so the
    // result register fills and the block stalls its input.
    initial begin : rx_stall
        int  mode;
        int  span;
        int  k;
        int  hold;
        bit  long_hold_done;
        i_ready        = 1'b0;
        long_hold_done = 1'b0;
        forever begin
            if (random_active && !long_hold_done) begin
                hold = $urandom_range(60, 150);
                i_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
                long_hold_done = 1'b1;
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 160);
            for (k = 0; k < span; k++) begin
                case (mode)
                    0:       i_ready <= 1'b1;
                    1:       i_ready <= 1'($urandom);
                    2:       i_ready <= (k % 3 == 0);
                    default: i_ready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Watchdog: end the run when nothing moves on either channel for too long.
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle = 0;
            else idle++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [CFG_W-1:0] cfg_values [6];
        int               ph;
        int               phase_end;
        cfg_values = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd0, RELEASE_STABILITY_RESET, 32'd37};
        cfg_values[3] = $urandom;

        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_wdata          = '0;
        i_valid              = 1'b0;
        i_link_generation    = '0;
        i_physical_connected = 1'b0;
        i_capture_active     = 1'b0;
        i_codec_path_active  = 1'b0;
        i_render_demand      = 1'b0;
        i_now_ms             = '0;
        gen_cur              = '0;
        now_cur              = '0;
        stab_cur             = RELEASE_STABILITY_RESET;
        sent                 = 0;
        burst_left           = 0;
        gap_free             = 1'b0;
        random_active        = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed walk with the reset release delay of 500 ms.
        send_status(64'd0, 1'b1, 1'b0, 1'b0, 1'b0, 64'd1000);   // invalid generation
        send_status(64'd5, 1'b0, 1'b0, 1'b0, 1'b0, 64'd1000);   // first generation, unplugged
        send_status(64'd5, 1'b1, 1'b0, 1'b0, 1'b0, 64'd1001);   // plugged: codec available
        send_status(64'd5, 1'b1, 1'b1, 1'b1, 1'b0, 64'd1002);   // capture on codec: stop it
        send_status(64'd5, 1'b1, 1'b1, 1'b1, 1'b1, 64'd1003);   // still waiting, no repeat stop
        send_status(64'd5, 1'b1, 1'b1, 1'b0, 1'b0, 64'd1004);   // codec stopped: enter voice
        send_status(64'd5, 1'b1, 1'b0, 1'b0, 1'b1, 64'd1005);   // capture ends: release delay
        send_status(64'd5, 1'b1, 1'b0, 1'b0, 1'b1, 64'd1504);   // one ms before the deadline
        send_status(64'd5, 1'b1, 1'b0, 1'b0, 1'b1, 64'd1505);   // deadline hit: exit and resume
        send_status(64'd4, 1'b1, 1'b1, 1'b0, 1'b0, 64'd1506);   // older generation
        send_status(64'd5 + GEN_HALF_SPAN, 1'b1, 1'b1, 1'b0, 1'b0, 64'd1506); // half range
        send_status(64'd0, 1'b0, 1'b1, 1'b1, 1'b1, 64'd1506);   // invalid again
        send_status(64'd5, 1'b1, 1'b1, 1'b0, 1'b1, 64'd1507);   // voice straight from codec avail
        send_status(64'd4 + GEN_HALF_SPAN, 1'b1, 1'b0, 1'b0, 1'b0, 64'd1508); // newest jump
        send_status(64'd4 + GEN_HALF_SPAN, 1'b1, 1'b1, 1'b0, 1'b0, 64'd1509);
        send_status(64'd4 + GEN_HALF_SPAN, 1'b0, 1'b1, 1'b0, 1'b0, 64'd1510); // unplug in voice
        send_status(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_status(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b1,
                    64'hFFFF_FFFF_FFFF_FFFF - 64'd499);             // deadline wraps to zero
        send_status(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b1, 64'd0); // due at once
        send_status(64'd3, 1'b1, 1'b1, 1'b1, 1'b0, 64'd10);     // generation wraps past zero
        send_status(64'd3, 1'b1, 1'b0, 1'b1, 1'b0, 64'd11);     // codec still running
        send_status(64'd3, 1'b1, 1'b0, 1'b0, 1'b1, 64'd12);     // codec stopped: release delay
        send_status(64'd3, 1'b1, 1'b0, 1'b0, 1'b1, 64'd511);
        send_status(64'd3, 1'b1, 1'b0, 1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF); // expire, no voice
        gen_cur = 64'd3;
        now_cur = 64'd100;

        // Random phases, one per release delay setting. Drain before every register
        // write so the block is idle; odd phases run the sender without gaps.
        for (ph = 0; ph < 6; ph++) begin
            drain_results();
            write_release_delay(cfg_values[ph]);
            random_active = 1'b1;
            gap_free  = ph[0];
            phase_end = sent + PHASE_ITEMS;
            while (sent < phase_end) begin
                if ($urandom_range(0, 9) < 6) play_switch_cycle();
                else send_noise();
            end
        end

        drain_results();
        if (fail_count == 0 && pending_results == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
